>>> rtl/core/stt_pkg.sv
// Shared types and constants for the software timer table.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package stt_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_CREATE = 3'd1,
        K_DELETE = 3'd2,
        K_START  = 3'd3,
        K_STOP   = 3'd4,
        K_QUERY  = 3'd5,
        K_RSVD6  = 3'd6,
        K_RSVD7  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        PH_UNUSED  = 2'd0,
        PH_STOPPED = 2'd1,
        PH_RUNNING = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_BAD_PERIOD = 3'd1;
    localparam logic [2:0] ST_BAD_DELAY  = 3'd2;
    localparam logic [2:0] ST_BAD_OPTION = 3'd3;
    localparam logic [2:0] ST_NONE_FREE  = 3'd4;
    localparam logic [2:0] ST_INACTIVE   = 3'd5;
    localparam logic [2:0] ST_NO_CB      = 3'd6;
    localparam logic [2:0] ST_STOPPED    = 3'd7;

    localparam logic [1:0] OPT_ONESHOT  = 2'd0;
    localparam logic [1:0] OPT_PERIODIC = 2'd1;
    localparam logic [1:0] OPT_CB       = 2'd1;
    localparam logic [1:0] OPT_CB_VALUE = 2'd2;
    localparam logic [1:0] OPT_INVALID  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_REPLY,
        S_SCAN_RD,
        S_SCAN_EV,
        S_FLUSH
    } t_state;

    // Per-timer record held in the datapath memory.
    typedef struct packed {
        logic        periodic;
        logic        cb_en;
        logic [31:0] delay;
        logic [31:0] period;
        logic [31:0] match;
        logic [31:0] cb_word;
    } t_rec;

    typedef struct packed {
        logic load;
        logic now_inc;
        logic rd;
        logic rd_scan;
        logic exec;
        logic reply_ok;
        logic idx_clr;
        logic idx_inc;
        logic scan_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic fires;
        logic scan_ev;
        logic pend;
        logic idx_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/core/stt_ctrl.sv
// Controller state machine for the software timer table.
// Depends on stt_pkg; drives the datapath through t_cmd and reads t_sts.
`default_nettype none
module stt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [2:0]    i_kind,
    output logic               o_stall,
    input  wire stt_pkg::t_sts i_sts,
    output stt_pkg::t_cmd      o_cmd
);
    import stt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (t_kind'(i_kind) == K_TICK) begin
                        o_cmd.now_inc = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_SCAN_RD;
                    end else if (t_kind'(i_kind) != K_RSVD6 &&
                                 t_kind'(i_kind) != K_RSVD7) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.fires ? S_REPLY : S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.reply_ok = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                // A new event displaces the held one, which needs the output slot.
                if (!(i_sts.scan_ev && i_sts.pend && !i_sts.out_free)) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_SCAN_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/stt_dpath.sv
// Datapath of the software timer table: timer record memory, phase flags,
// free stack, tick time and the output register. Depends on stt_pkg.
`default_nettype none
module stt_dpath #(
    parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stt_pkg::t_cmd i_cmd,
    output stt_pkg::t_sts      o_sts,
    input  wire logic [2:0]    i_kind,
    input  wire logic [3:0]    i_timer,
    input  wire logic [31:0]   i_delay,
    input  wire logic [31:0]   i_period,
    input  wire logic [1:0]    i_option,
    input  wire logic          i_has_callback,
    input  wire logic [31:0]   i_cb_value,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_ok,
    output logic [2:0]         o_status,
    output logic [3:0]         o_handle,
    output logic [31:0]        o_remain,
    output logic               o_fired,
    output logic [31:0]        o_event_value,
    output logic               o_last
);
    import stt_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Latched item.
    t_kind       r_kind;
    logic [3:0]  r_t;
    logic [31:0] r_delay, r_period, r_cbv;
    logic [1:0]  r_opt;
    logic        r_hascb;

    logic [31:0]   r_now;
    logic [IW-1:0] r_idx;
    logic [IW:0]   r_fc;

    t_rec          r_mem [NUM_TIMERS];
    t_rec          r_rd;
    t_phase        r_phase [NUM_TIMERS];
    logic [IW-1:0] r_stk [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_svld;
    logic [IW-1:0] r_stk_rd;
    logic          r_stk_rd_vld;

    logic          r_pend;
    logic [IW-1:0] r_pend_h;
    logic [31:0]   r_pend_v;

    logic          r_ov;
    logic          r_ok, r_fired, r_last;
    logic [2:0]    r_status;
    logic [3:0]    r_handle;
    logic [31:0]   r_remain, r_value;

    logic [IW-1:0] tidx, stk_top, pop_idx, ph_wa, mem_wa;
    logic          t_in, out_free, hit, scan_ev;
    t_phase        ph_t, ph_wd;
    logic          ph_we, mem_we, push, stk_push, stk_pop;
    t_rec          mem_wd;
    logic          p_ok, p_fired, p_last, fires;
    logic [2:0]    p_status;
    logic [3:0]    p_handle;
    logic [31:0]   p_remain, p_value, arm_d;

    assign tidx     = IW'(r_t);
    assign t_in     = (int'(r_t) < NUM_TIMERS);
    assign stk_top  = IW'(r_fc - 1'b1);
    assign pop_idx  = r_stk_rd_vld ? r_stk_rd : (IW'(NUM_TIMERS - 1) - stk_top);
    assign out_free = !r_ov || !i_stall;
    assign ph_t     = t_in ? r_phase[tidx] : PH_UNUSED;
    assign hit      = (r_phase[r_idx] == PH_RUNNING) && (r_rd.match == r_now);
    assign scan_ev  = hit && r_rd.cb_en;
    assign arm_d    = (r_rd.delay != 32'd0) ? r_rd.delay : r_rd.period;

    always_comb begin
        o_sts          = '0;
        o_sts.scan_ev  = scan_ev;
        o_sts.pend     = r_pend;
        o_sts.idx_last = (int'(r_idx) == NUM_TIMERS - 1);
        o_sts.out_free = out_free;
        o_sts.fires    = fires;
    end

    // Command execution, scan step and result selection.
    always_comb begin
        ph_we    = 1'b0;
        ph_wa    = tidx;
        ph_wd    = PH_UNUSED;
        mem_we   = 1'b0;
        mem_wa   = tidx;
        mem_wd   = r_rd;
        stk_push = 1'b0;
        stk_pop  = 1'b0;
        push     = 1'b0;
        fires    = 1'b0;
        p_ok     = 1'b0;
        p_status = ST_NONE;
        p_handle = 4'd0;
        p_remain = 32'd0;
        p_fired  = 1'b0;
        p_value  = 32'd0;
        p_last   = 1'b1;
        if (r_kind == K_STOP && ph_t == PH_RUNNING &&
            (r_opt == OPT_CB || r_opt == OPT_CB_VALUE) && r_rd.cb_en) begin
            fires = 1'b1;
        end
        if (i_cmd.exec) begin
            push = 1'b1;
            case (r_kind)
                K_CREATE: begin
                    if (r_opt == OPT_PERIODIC && r_period == 32'd0) begin
                        p_status = ST_BAD_PERIOD;
                    end else if (r_opt == OPT_ONESHOT && r_delay == 32'd0) begin
                        p_status = ST_BAD_DELAY;
                    end else if (r_opt[1]) begin
                        p_status = ST_BAD_OPTION;
                    end else if (r_fc == '0) begin
                        p_status = ST_NONE_FREE;
                    end else begin
                        stk_pop  = 1'b1;
                        ph_we    = 1'b1;
                        ph_wa    = pop_idx;
                        ph_wd    = PH_STOPPED;
                        mem_we   = 1'b1;
                        mem_wa   = pop_idx;
                        mem_wd   = '{periodic: r_opt[0], cb_en: r_hascb, delay: r_delay,
                                     period: r_period, match: 32'd0, cb_word: r_cbv};
                        p_ok     = 1'b1;
                        p_handle = 4'(pop_idx);
                    end
                end
                K_DELETE: begin
                    if (ph_t == PH_UNUSED) begin
                        p_status = ST_INACTIVE;
                    end else begin
                        ph_we    = 1'b1;
                        ph_wd    = PH_UNUSED;
                        stk_push = (int'(r_fc) < NUM_TIMERS);
                        p_ok     = 1'b1;
                    end
                end
                K_START: begin
                    if (ph_t == PH_UNUSED) begin
                        p_status = ST_INACTIVE;
                    end else begin
                        ph_we        = 1'b1;
                        ph_wd        = PH_RUNNING;
                        mem_we       = 1'b1;
                        mem_wd.match = arm_d + r_now;
                        p_ok         = 1'b1;
                    end
                end
                K_STOP: begin
                    if (ph_t == PH_UNUSED) begin
                        p_status = ST_INACTIVE;
                    end else if (ph_t != PH_RUNNING) begin
                        p_ok     = 1'b1;
                        p_status = ST_STOPPED;
                    end else begin
                        ph_we = 1'b1;
                        ph_wd = PH_STOPPED;
                        if (fires) begin
                            p_handle = r_t;
                            p_fired  = 1'b1;
                            p_value  = (r_opt == OPT_CB) ? r_rd.cb_word : r_cbv;
                            p_last   = 1'b0;
                        end else begin
                            p_ok = 1'b1;
                            case (r_opt) inside
                                OPT_CB, OPT_CB_VALUE: p_status = ST_NO_CB;
                                OPT_INVALID:          p_status = ST_BAD_OPTION;
                                default:              p_status = ST_NONE;
                            endcase
                        end
                    end
                end
                K_QUERY: begin
                    if (ph_t == PH_UNUSED) begin
                        p_status = ST_INACTIVE;
                    end else begin
                        p_ok = 1'b1;
                        if (ph_t == PH_RUNNING) begin
                            p_remain = r_rd.match - r_now;
                        end else if (ph_t == PH_STOPPED) begin
                            p_remain = (r_rd.periodic && r_rd.delay == 32'd0) ?
                                       r_rd.period : r_rd.delay;
                        end
                    end
                end
                default: push = 1'b0;
            endcase
        end else if (i_cmd.reply_ok) begin
            push = 1'b1;
            p_ok = 1'b1;
        end else if (i_cmd.scan_step) begin
            ph_wa  = r_idx;
            mem_wa = r_idx;
            if (hit) begin
                if (r_rd.periodic) begin
                    mem_we       = 1'b1;
                    mem_wd.match = r_rd.period + r_now;
                end else begin
                    ph_we = 1'b1;
                    ph_wd = PH_DONE;
                end
            end
            if (hit && r_rd.cb_en && r_pend) begin
                push     = 1'b1;
                p_handle = 4'(r_pend_h);
                p_fired  = 1'b1;
                p_value  = r_pend_v;
                p_last   = 1'b0;
            end
        end else if (i_cmd.flush) begin
            push     = 1'b1;
            p_handle = 4'(r_pend_h);
            p_fired  = 1'b1;
            p_value  = r_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_t      <= i_timer;
            r_delay  <= i_delay;
            r_period <= i_period;
            r_opt    <= i_option;
            r_hascb  <= i_has_callback;
            r_cbv    <= i_cb_value;
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[tidx];
        end else if (i_cmd.rd_scan) begin
            r_rd <= r_mem[r_idx];
        end
        if (i_cmd.rd) begin
            r_stk_rd     <= r_stk[stk_top];
            r_stk_rd_vld <= r_svld[stk_top];
        end
        if (stk_push) begin
            r_stk[IW'(r_fc)] <= tidx;
        end
        if (i_cmd.scan_step && scan_ev) begin
            r_pend_h <= r_idx;
            r_pend_v <= r_rd.cb_word;
        end
        if (push) begin
            r_ok     <= p_ok;
            r_status <= p_status;
            r_handle <= p_handle;
            r_remain <= p_remain;
            r_fired  <= p_fired;
            r_value  <= p_value;
            r_last   <= p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_idx  <= '0;
            r_fc   <= (IW + 1)'(NUM_TIMERS);
            r_svld <= '0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_phase[k] <= PH_UNUSED;
            end
        end else begin
            if (i_cmd.now_inc) begin
                r_now <= r_now + 32'd1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (ph_we) begin
                r_phase[ph_wa] <= ph_wd;
            end
            if (stk_push) begin
                r_svld[IW'(r_fc)] <= 1'b1;
                r_fc              <= r_fc + 1'b1;
            end else if (stk_pop) begin
                r_fc <= r_fc - 1'b1;
            end
            if (i_cmd.scan_step && scan_ev) begin
                r_pend <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend <= 1'b0;
            end
            if (push) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_ok          = r_ok;
    assign o_status      = r_status;
    assign o_handle      = r_handle;
    assign o_remain      = r_remain;
    assign o_fired       = r_fired;
    assign o_event_value = r_value;
    assign o_last        = r_last;

endmodule
`default_nettype wire

>>> rtl/core/software_timer_table.sv
// Software timer table: a pool of NUM_TIMERS one-shot or periodic timers with a
// 32-bit tick time. Items are taken one at a time. A command passes through the
// steps register the item, read the timer record and execute, plus a reply step for
// a stop that delivers a callback event; a tick scans the timer memory one entry
// at a time (read, then compare and update), and the consumer can hold any step
// that writes the output register by stalling it. Events of a tick come out in
// timer index order, the last one flagged with last. Depends on stt_pkg,
// stt_ctrl and stt_dpath.
`default_nettype none
module software_timer_table #(
    parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [3:0]  i_timer,
    input  wire logic [31:0] i_delay,
    input  wire logic [31:0] i_period,
    input  wire logic [1:0]  i_option,
    input  wire logic        i_has_callback,
    input  wire logic [31:0] i_cb_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_ok,
    output logic [2:0]       o_status,
    output logic [3:0]       o_handle,
    output logic [31:0]      o_remain,
    output logic             o_fired,
    output logic [31:0]      o_event_value,
    output logic             o_last
);
    import stt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stt_dpath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_timer        (i_timer),
        .i_delay        (i_delay),
        .i_period       (i_period),
        .i_option       (i_option),
        .i_has_callback (i_has_callback),
        .i_cb_value     (i_cb_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_ok           (o_ok),
        .o_status       (o_status),
        .o_handle       (o_handle),
        .o_remain       (o_remain),
        .o_fired        (o_fired),
        .o_event_value  (o_event_value),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

>>> dv/tb_software_timer_table.sv
// Self-checking testbench for software_timer_table: directed and random commands and ticks,
// with results checked by a scoreboard class that tracks the timer pool itself.
// Depends on stt_pkg and the software_timer_table RTL only.
module tb_software_timer_table;
    import stt_pkg::*;

    localparam int N_TMR       = 16;
    localparam int CYCLE_LIMIT = 800000;
    localparam int N_RANDOM    = 460;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  timer;
        logic [31:0] delay;
        logic [31:0] period;
        logic [1:0]  option;
        logic        has_cb;
        logic [31:0] cb_value;
    } cmd_t;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [3:0]  handle;
        logic [31:0] remain;
        logic        fired;
        logic [31:0] value;
        logic        last;
    } reply_t;

    class timer_scoreboard;
        t_phase      phase [N_TMR];
        bit          periodic [N_TMR];
        bit [31:0]   dly [N_TMR];
        bit [31:0]   per [N_TMR];
        bit [31:0]   match [N_TMR];
        bit          cb_en [N_TMR];
        bit [31:0]   cb_word [N_TMR];
        bit [31:0]   now;
        bit [3:0]    free_stack [N_TMR];
        int          free_cnt;
        reply_t      pending_q [$];
        int          errors;

        function new();
            for (int i = 0; i < N_TMR; i++) begin
                phase[i] = PH_UNUSED;
                periodic[i] = 0;
                dly[i] = 0;
                per[i] = 0;
                match[i] = 0;
                cb_en[i] = 0;
                cb_word[i] = 0;
                free_stack[i] = 4'(N_TMR - 1 - i);
            end
            now = 0;
            free_cnt = N_TMR;
            errors = 0;
        endfunction

        function void push(logic ok, logic [2:0] st, logic [3:0] h, logic [31:0] rem,
                           logic fired, logic [31:0] val, logic last);
            reply_t r;
            r = '{ok, st, h, rem, fired, val, last};
            pending_q.push_back(r);
        endfunction

        function void arm(int t);
            bit [31:0] d;
            d = (dly[t] != 0) ? dly[t] : per[t];
            phase[t] = PH_RUNNING;
            match[t] = d + now;
        endfunction

        // Works out the results of one accepted transfer and updates the pool.
        function void note_input(cmd_t c);
            int     t;
            int     first;
            int     h;
            t_phase ph;
            bit [31:0] rem;
            t = c.timer;
            ph = phase[t];
            first = pending_q.size();
            case (c.kind)
                K_TICK: begin
                    now++;
                    for (int i = 0; i < N_TMR; i++) begin
                        if (phase[i] == PH_RUNNING && match[i] == now) begin
                            if (periodic[i]) match[i] = per[i] + now;
                            else phase[i] = PH_DONE;
                            if (cb_en[i]) begin
                                if (pending_q.size() > first)
                                    pending_q[pending_q.size() - 1].last = 0;
                                push(0, ST_NONE, 4'(i), 0, 1, cb_word[i], 1);
                            end
                        end
                    end
                end
                K_CREATE: begin
                    if (c.option == OPT_PERIODIC && c.period == 0)
                        push(0, ST_BAD_PERIOD, 0, 0, 0, 0, 1);
                    else if (c.option == OPT_ONESHOT && c.delay == 0)
                        push(0, ST_BAD_DELAY, 0, 0, 0, 0, 1);
                    else if (c.option > OPT_PERIODIC)
                        push(0, ST_BAD_OPTION, 0, 0, 0, 0, 1);
                    else if (free_cnt == 0)
                        push(0, ST_NONE_FREE, 0, 0, 0, 0, 1);
                    else begin
                        free_cnt--;
                        h = free_stack[free_cnt];
                        phase[h] = PH_STOPPED;
                        periodic[h] = c.option[0];
                        dly[h] = c.delay;
                        per[h] = c.period;
                        cb_en[h] = c.has_cb;
                        cb_word[h] = c.cb_value;
                        push(1, ST_NONE, 4'(h), 0, 0, 0, 1);
                    end
                end
                K_DELETE: begin
                    if (ph == PH_UNUSED) push(0, ST_INACTIVE, 0, 0, 0, 0, 1);
                    else begin
                        // The delay is deliberately kept; everything else is cleared.
                        phase[t] = PH_UNUSED;
                        periodic[t] = 0;
                        per[t] = 0;
                        match[t] = 0;
                        cb_en[t] = 0;
                        cb_word[t] = 0;
                        if (free_cnt < N_TMR) begin
                            free_stack[free_cnt] = 4'(t);
                            free_cnt++;
                        end
                        push(1, ST_NONE, 0, 0, 0, 0, 1);
                    end
                end
                K_START: begin
                    if (ph == PH_UNUSED) push(0, ST_INACTIVE, 0, 0, 0, 0, 1);
                    else begin
                        arm(t);
                        push(1, ST_NONE, 0, 0, 0, 0, 1);
                    end
                end
                K_STOP: begin
                    if (ph == PH_UNUSED) push(0, ST_INACTIVE, 0, 0, 0, 0, 1);
                    else if (ph != PH_RUNNING) push(1, ST_STOPPED, 0, 0, 0, 0, 1);
                    else begin
                        phase[t] = PH_STOPPED;
                        if (c.option == OPT_CB || c.option == OPT_CB_VALUE) begin
                            if (cb_en[t]) begin
                                push(0, ST_NONE, 4'(t), 0, 1,
                                     (c.option == OPT_CB) ? cb_word[t] : c.cb_value, 0);
                                push(1, ST_NONE, 0, 0, 0, 0, 1);
                            end else
                                push(1, ST_NO_CB, 0, 0, 0, 0, 1);
                        end else
                            push(1, (c.option == OPT_INVALID) ? ST_BAD_OPTION : ST_NONE,
                                 0, 0, 0, 0, 1);
                    end
                end
                K_QUERY: begin
                    if (ph == PH_UNUSED) push(0, ST_INACTIVE, 0, 0, 0, 0, 1);
                    else begin
                        rem = 0;
                        if (ph == PH_RUNNING) rem = match[t] - now;
                        else if (ph == PH_STOPPED)
                            rem = (periodic[t] && dly[t] == 0) ? per[t] : dly[t];
                        push(1, ST_NONE, 0, rem, 0, 0, 1);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(reply_t got);
            reply_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
            end else begin
                want = pending_q.pop_front();
                if (got.ok !== want.ok || got.status !== want.status ||
                    got.handle !== want.handle || got.remain !== want.remain ||
                    got.fired !== want.fired || got.value !== want.value ||
                    got.last !== want.last)
                    report($sformatf("got %p want %p", got, want));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_kind;
    logic [3:0]  i_timer;
    logic [31:0] i_delay;
    logic [31:0] i_period;
    logic [1:0]  i_option;
    logic        i_has_callback;
    logic [31:0] i_cb_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_ok;
    logic [2:0]  o_status;
    logic [3:0]  o_handle;
    logic [31:0] o_remain;
    logic        o_fired;
    logic [31:0] o_event_value;
    logic        o_last;

    timer_scoreboard sb;
    int cycles;
    int long_hold;
    int run_left;
    bit quiet;

    software_timer_table u_dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_kind = K_TICK;
        i_timer = 0;
        i_delay = 0;
        i_period = 0;
        i_option = 0;
        i_has_callback = 0;
        i_cb_value = 0;
        cycles = 0;
        long_hold = 0;
        run_left = 0;
        quiet = 0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[software_timer_table] ERROR");
            $finish;
        end
    end

    // Receiver side: random stall bursts, plus one long hold-off on request; no stalls once quiet is set.
    always @(posedge i_clk) begin
        if (long_hold > 0) begin
            long_hold--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(0, 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_ok, o_status, o_handle, o_remain, o_fired, o_event_value,
                              o_last});
    end

    function automatic cmd_t mk(t_kind k, int t, logic [31:0] d, logic [31:0] p,
                                logic [1:0] opt, logic cb, logic [31:0] v);
        cmd_t c;
        c = '{k, 4'(t), d, p, opt, cb, v};
        return c;
    endfunction

    function automatic logic [31:0] rand_ticks();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // Mostly well-formed traffic aimed at live timers, with some noise mixed in.
    function automatic cmd_t make_random();
        cmd_t c;
        int   w;
        c.delay = rand_ticks();
        c.period = rand_ticks();
        c.cb_value = $urandom();
        c.has_cb = ($urandom_range(0, 3) != 0);
        c.option = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(2, 3))
                                                : 2'($urandom_range(0, 1));
        c.timer = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 4) != 0)
            for (int i = 0; i < 8 && sb.phase[c.timer] == PH_UNUSED; i++)
                c.timer = 4'($urandom_range(0, 15));
        w = $urandom_range(0, 99);
        if (w < 40)      c.kind = K_TICK;
        else if (w < 55) c.kind = K_CREATE;
        else if (w < 70) c.kind = K_START;
        else if (w < 80) begin
            c.kind = K_STOP;
            c.option = 2'($urandom_range(0, 3));
        end
        else if (w < 90) c.kind = K_QUERY;
        else if (w < 97) c.kind = K_DELETE;
        else             c.kind = ($urandom_range(0, 1) != 0) ? K_RSVD6 : K_RSVD7;
        return c;
    endfunction

    task automatic send_item(cmd_t c);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= c.kind;
        i_timer <= c.timer;
        i_delay <= c.delay;
        i_period <= c.period;
        i_option <= c.option;
        i_has_callback <= c.has_cb;
        i_cb_value <= c.cb_value;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(c);
    endtask

    initial begin
        cmd_t dir_q [$];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_q = '{
            mk(K_CREATE, 0, 1, 0, OPT_ONESHOT, 1, 32'hA5A5_A5A5),
            mk(K_CREATE, 0, 0, 2, OPT_PERIODIC, 1, 32'hFFFF_FFFF),
            mk(K_CREATE, 0, 5, 0, OPT_PERIODIC, 1, 1),
            mk(K_CREATE, 0, 0, 5, OPT_ONESHOT, 1, 1),
            mk(K_CREATE, 0, 3, 3, OPT_CB_VALUE, 0, 0),
            mk(K_CREATE, 0, 3, 3, OPT_INVALID, 0, 0),
            mk(K_CREATE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OPT_ONESHOT, 0, 0),
            mk(K_QUERY, 0, 0, 0, 0, 0, 0),
            mk(K_QUERY, 1, 0, 0, 0, 0, 0),
            mk(K_START, 0, 0, 0, 0, 0, 0),
            mk(K_START, 1, 0, 0, 0, 0, 0),
            mk(K_START, 2, 0, 0, 0, 0, 0),
            mk(K_TICK, 0, 0, 0, 0, 0, 0),
            mk(K_TICK, 0, 0, 0, 0, 0, 0),
            mk(K_QUERY, 0, 0, 0, 0, 0, 0),
            mk(K_QUERY, 2, 0, 0, 0, 0, 0),
            mk(K_STOP, 1, 0, 0, OPT_CB_VALUE, 0, 32'h1234_5678),
            mk(K_STOP, 1, 0, 0, OPT_CB, 0, 0),
            mk(K_START, 1, 0, 0, 0, 0, 0),
            mk(K_STOP, 1, 0, 0, OPT_INVALID, 0, 0),
            mk(K_START, 1, 0, 0, 0, 0, 0),
            mk(K_STOP, 1, 0, 0, OPT_CB, 0, 0),
            mk(K_STOP, 2, 0, 0, OPT_CB, 0, 0),
            mk(K_DELETE, 0, 0, 0, 0, 0, 0),
            mk(K_DELETE, 0, 0, 0, 0, 0, 0),
            mk(K_START, 15, 0, 0, 0, 0, 0),
            mk(K_STOP, 15, 0, 0, OPT_ONESHOT, 0, 0),
            mk(K_QUERY, 15, 0, 0, 0, 0, 0),
            mk(K_RSVD6, 0, 0, 0, 0, 0, 0),
            mk(K_RSVD7, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11, 1, 32'hFFFF_FFFF)
        };
        foreach (dir_q[i]) send_item(dir_q[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            // Hold the output off for a long stretch so that the block backs up.
            if (n == 120) long_hold = 400;
            if (n == 250) begin
                i_valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge i_clk);
            end
            if (n == N_RANDOM - 60) quiet = 1;
            send_item(make_random());
        end
        i_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[software_timer_table] OK");
        else
            $display("[software_timer_table] ERROR");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/stt_pkg.sv
rtl/core/stt_ctrl.sv
rtl/core/stt_dpath.sv
rtl/core/software_timer_table.sv
dv/tb_software_timer_table.sv
